[design/bce_pkg.sv]
// ----------------------------------------------------------------------------
// bce_pkg
// Shared types, constants and tables for the binary cross-entropy loss unit.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int unsigned ACC_WIDTH_DEF   = 40;
  localparam int unsigned COUNT_WIDTH_DEF = 24;
  localparam int unsigned PROB_W          = 17;
  localparam int unsigned LN_W            = 20;
  localparam int unsigned OUT_W           = 40;
  localparam int unsigned MODE_W          = 2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [19:0] LN2_Q16 = 20'd45426;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SUM  = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_LOG,
    ST_MUL,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } bce_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic norm;
    logic log_step;
    logic mul;
    logic acc;
    logic div_start;
    logic div_step;
    logic clear;
  } bce_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic norm_done;
    logic log_done;
    logic div_done;
  } bce_stat_t;

  // round(ln(1+2^-j) * 65536)
  function automatic logic [19:0] ln_step(input logic [4:0] j);
    case (j)
      5'd1:  ln_step = 20'd26572;
      5'd2:  ln_step = 20'd14624;
      5'd3:  ln_step = 20'd7719;
      5'd4:  ln_step = 20'd3973;
      5'd5:  ln_step = 20'd2017;
      5'd6:  ln_step = 20'd1016;
      5'd7:  ln_step = 20'd510;
      5'd8:  ln_step = 20'd256;
      5'd9:  ln_step = 20'd128;
      5'd10: ln_step = 20'd64;
      5'd11: ln_step = 20'd32;
      5'd12: ln_step = 20'd16;
      5'd13: ln_step = 20'd8;
      5'd14: ln_step = 20'd4;
      5'd15: ln_step = 20'd2;
      5'd16: ln_step = 20'd1;
      default: ln_step = 20'd0;
    endcase
  endfunction

endpackage

[design/bce_ctrl.sv]
// ----------------------------------------------------------------------------
// bce_ctrl
// Sequencer: load, normalize, log iterations, multiply, accumulate or emit, divide, output.
// ----------------------------------------------------------------------------
module bce_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      last,
  input  logic [bce_pkg::MODE_W-1:0] mode,
  input  bce_pkg::bce_stat_t        stat,
  output bce_pkg::bce_cmd_t         cmd,
  output logic                      emit,
  output logic                      emit_end
);
  import bce_pkg::*;

  bce_state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    emit       = 1'b0;
    emit_end   = 1'b0;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_NORM;
        end
      end
      ST_NORM: begin
        cmd.norm = 1'b1;
        if (stat.norm_done) begin
          state_next = ST_LOG;
        end
      end
      ST_LOG: begin
        cmd.log_step = 1'b1;
        if (stat.log_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (mode == MODE_NONE) begin
          if (!out_valid || !out_stall) begin
            emit       = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.acc = 1'b1;
          if (!last) begin
            state_next = ST_IDLE;
          end else if (mode == MODE_SUM) begin
            state_next = ST_OUT;
          end else begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          emit       = 1'b1;
          emit_end   = 1'b1;
          cmd.clear  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    cmd.div_start = (state == ST_ACC) && (mode != MODE_NONE) && last && (mode != MODE_SUM);
  end

endmodule

[design/bce_datapath.sv]
// ----------------------------------------------------------------------------
// bce_datapath
// Clamp, shift-and-add logs (two in parallel), weighting, accumulator and
// restoring divider for the mean.
// ----------------------------------------------------------------------------
module bce_datapath #(
  parameter int unsigned ACC_WIDTH   = bce_pkg::ACC_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = bce_pkg::COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bce_pkg::bce_cmd_t          cmd,
  input  logic [bce_pkg::PROB_W-1:0] pred_prob,
  input  logic [bce_pkg::PROB_W-1:0] target_prob,
  output bce_pkg::bce_stat_t         stat,
  output logic [bce_pkg::OUT_W-1:0]  loss_elem,
  output logic [bce_pkg::OUT_W-1:0]  loss_red
);
  import bce_pkg::*;

  localparam int unsigned QW = ACC_WIDTH + 1;
  localparam int unsigned VW = QW + OUT_W;
  localparam int unsigned DCW = $clog2(ACC_WIDTH + 1);
  localparam logic [ACC_WIDTH-1:0]   ACC_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
  localparam logic [DCW-1:0] DIV_LAST = DCW'(ACC_WIDTH - 1);

  logic [16:0] ya, yb, t;
  logic [19:0] ra, rb;
  logic [4:0]  j;
  logic [37:0] loss;
  logic [ACC_WIDTH-1:0]   sum;
  logic [COUNT_WIDTH-1:0] cnt;
  logic [ACC_WIDTH-1:0]   quo;
  logic [COUNT_WIDTH:0]   rem;
  logic [DCW-1:0]         dcnt;
  logic [QW-1:0]          mean;
  logic                   mean_sel;

  logic [16:0] p_cl;
  logic [16:0] na, nb;
  logic        ga, gb;
  logic [37:0] prod;
  logic [ACC_WIDTH:0] sum_add;
  logic [COUNT_WIDTH:0] rem_sh;
  logic [COUNT_WIDTH+1:0] dbl;

  // clamp prediction
  always_comb begin
    p_cl = pred_prob;
    if (pred_prob == 17'd0) p_cl = 17'd1;
    if (pred_prob > 17'd65535) p_cl = 17'd65535;
  end

  assign na = ya + (ya >> j);
  assign nb = yb + (yb >> j);
  assign ga = na <= ONE_Q16;
  assign gb = nb <= ONE_Q16;
  assign stat.norm_done = ya[15] && yb[15];
  assign stat.log_done  = (j == 5'd16);
  assign stat.div_done  = (dcnt == DIV_LAST);

  // weighted log sum with rounding
  assign prod = 38'(t) * 38'(ra) + 38'(ONE_Q16 - t) * 38'(rb) + 38'd32768;

  // log iterations
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ya <= p_cl;
      yb <= ONE_Q16 - p_cl;
      t  <= (target_prob > ONE_Q16) ? ONE_Q16 : target_prob;
      ra <= '0;
      rb <= '0;
      j  <= 5'd1;
    end else if (cmd.norm) begin
      if (!ya[15]) begin
        ya <= ya << 1;
        ra <= ra + LN2_Q16;
      end
      if (!yb[15]) begin
        yb <= yb << 1;
        rb <= rb + LN2_Q16;
      end
    end else if (cmd.log_step) begin
      if (ga) begin
        ya <= na;
        ra <= ra + ln_step(j);
      end
      if (gb) begin
        yb <= nb;
        rb <= rb + ln_step(j);
      end
      j <= j + 5'd1;
    end
    if (cmd.mul) begin
      loss <= prod >> 16;
    end
  end

  assign sum_add = {1'b0, sum} + (ACC_WIDTH+1)'(loss[21:0]);
  assign rem_sh  = {rem[COUNT_WIDTH-1:0], quo[ACC_WIDTH-1]};

  // accumulate, count, divide
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sum <= '0;
      cnt <= '0;
    end else if (cmd.acc) begin
      sum <= sum_add[ACC_WIDTH] ? ACC_MAX : sum_add[ACC_WIDTH-1:0];
      if (cnt != CNT_MAX) cnt <= cnt + 1'b1;
    end
    // remember whether this run closes with a mean
    if (cmd.acc) mean_sel <= cmd.div_start;
    if (cmd.div_start) begin
      quo  <= sum_add[ACC_WIDTH] ? ACC_MAX : sum_add[ACC_WIDTH-1:0];
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, cnt}) begin
        rem <= rem_sh - {1'b0, cnt};
        quo <= {quo[ACC_WIDTH-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[ACC_WIDTH-2:0], 1'b0};
      end
      dcnt <= dcnt + 1'b1;
    end
  end

  // round half up: rem >= cnt - rem
  assign dbl  = {1'b0, rem} << 1;
  assign mean = {1'b0, quo} + QW'(dbl >= (COUNT_WIDTH+2)'(cnt));

  assign loss_elem = OUT_W'(loss[21:0]);

  // pick total or mean, saturate to output width
  always_comb begin
    logic [VW-1:0] v;
    v = mean_sel ? VW'(mean) : VW'(sum);
    if (v > VW'({OUT_W{1'b1}})) loss_red = '1;
    else loss_red = v[OUT_W-1:0];
  end

endmodule

[design/binary_cross_entropy_loss_unit.sv]
// ----------------------------------------------------------------------------
// binary_cross_entropy_loss_unit
// Streams prediction/target pairs and emits per-element BCE loss, or the
// run total or rounded mean on the marked last element.
// ----------------------------------------------------------------------------
// channel  direction  handshake          payload
// in       input      in_valid/in_stall  pred_prob, target_prob, last_element
// out      output     out_valid/out_stall loss_value, end_of_run
// cfg      input      cfg_valid/cfg_ready cfg_data (reduction_mode)
//
// Each item runs through these steps in order before the next is accepted:
// accept, normalize (up to 15 shifts and a check), 16 log iterations, one
// multiply and one accumulate or emit step. The last item of a sum run adds
// an output step; of a mean run, ACC_WIDTH steps of the one-bit restoring
// divider and an output step.
// Reset clears mode, accumulator, count and the output valid flag.
// A held result in the output register does not block the log work of
// the next item; only its own emit waits for the output to free.
// ----------------------------------------------------------------------------
module binary_cross_entropy_loss_unit #(
  parameter int unsigned ACC_WIDTH   = bce_pkg::ACC_WIDTH_DEF,
  parameter int unsigned COUNT_WIDTH = bce_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bce_pkg::PROB_W-1:0]  pred_prob,
  input  logic [bce_pkg::PROB_W-1:0]  target_prob,
  input  logic                        last_element,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bce_pkg::OUT_W-1:0]   loss_value,
  output logic                        end_of_run,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bce_pkg::MODE_W-1:0]  cfg_data
);
  import bce_pkg::*;

  bce_cmd_t  cmd;
  bce_stat_t stat;
  logic [MODE_W-1:0] mode;
  logic              last;
  logic              emit, emit_end;
  logic [OUT_W-1:0]  loss_elem, loss_red;

  assign cfg_ready = 1'b1;

  // mode register and item mark
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
    end else if (cfg_valid) begin
      mode <= cfg_data;
    end
    if (cmd.load) last <= last_element;
  end

  bce_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .last, .mode, .stat, .cmd, .emit, .emit_end
  );

  bce_datapath #(.ACC_WIDTH(ACC_WIDTH), .COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk, .rst, .cmd, .pred_prob, .target_prob, .stat, .loss_elem, .loss_red
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (emit) begin
      loss_value <= emit_end ? loss_red : loss_elem;
      end_of_run <= emit_end;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!out_valid || !out_stall))
    else $error("emit while output held");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> in_stall)
    else $error("item accepted while busy");
  a_clear_end: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (out_valid && end_of_run))
    else $error("run cleared without result");

endmodule
